// ===== src/ledenc_pkg.sv =====
// Shared types, codes and constants for the LED table encoder.
// Used by ledenc_enc, the top level and the testbench; depends on nothing.
`default_nettype none

package ledenc_pkg;

  // Table size and index widths
  localparam int LED_COUNT = 16;
  localparam int IN_IDX_W  = 5;
  localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IN_IDX_W-1:0]  LED_COUNT_IX = IN_IDX_W'(LED_COUNT);
  localparam logic [LED_IDX_W-1:0] LED_LAST     = LED_IDX_W'(LED_COUNT - 1);

  // Pattern bytes after reset
  localparam logic [7:0] ONE_PATTERN_RST  = 8'hF8;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'hC0;

  // Configuration register indexes
  localparam logic CFG_ONE_PATTERN  = 1'b0;
  localparam logic CFG_ZERO_PATTERN = 1'b1;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_BLINK   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Power modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_BLACK = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BYTE_GREEN,
    BYTE_RED,
    BYTE_BLUE
  } byte_sel_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [IN_IDX_W-1:0] led_num;
    logic [1:0]          power_mode;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
  } in_item_t;

  typedef struct packed {
    logic [63:0] spi_word;
    logic        last;
  } out_item_t;

  // One table entry: mode above color (red, green, blue from top)
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] color;
  } led_entry_t;

  localparam int ENTRY_W = $bits(led_entry_t);

  // Request from the sequencer to the encoder stage
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
  } enc_req_t;

endpackage

`default_nettype wire

// ===== src/ledenc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ledenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/ledenc_enc.sv =====
// Output stage: expands one color byte into eight SPI pattern bytes and registers it.
// Depends on ledenc_pkg.
`default_nettype none

module ledenc_enc (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ledenc_pkg::enc_req_t  req,
  input  wire logic [7:0]            one_pattern,
  input  wire logic [7:0]            zero_pattern,
  output logic                       out_valid,
  output ledenc_pkg::out_item_t      out_item
);

  logic                  valid_r;
  ledenc_pkg::out_item_t item_r;
  ledenc_pkg::out_item_t item_nxt;

  // Map each data bit to a pattern byte, MSB into the top byte
  always_comb begin
    item_nxt.last = req.last;
    for (int b = 0; b < 8; b++) begin
      item_nxt.spi_word[b*8 +: 8] = req.data[b] ? one_pattern : zero_pattern;
    end
  end

  // Strobe for one cycle per emitted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.emit;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (req.emit) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// ===== src/rgb_led_table_ws2812_encoder_unit.sv =====
// Top level of the LED table encoder: command decode, refresh sequencer, table RAM.
// Depends on ledenc_pkg, ledenc_ram and ledenc_enc.
//
// Usage:
//   Commands enter on in_item, taken at a clock edge with start high and busy low.
//   A write command stores one LED's color and mode and yields no item; empty writes
//   (LED 0, mode off) and out-of-range indexes are dropped. A blink tick toggles the
//   blink phase and then refreshes; a refresh emits three items per LED (green, red,
//   blue), each the eight pattern bytes of one color byte, with last set on the final
//   item of the frame. A refresh holds busy through the read state and the emit steps
//   of all items: the table RAM has one read port and is read once per LED, the read
//   of the next LED issued during the blue byte of the current one, so one item leaves
//   per cycle. The first item passes the read state, the emit state and the encoder's
//   output register; a new command may be taken in the cycle that shows the last item.
//   Results strobe out_valid for exactly one cycle; the receiver cannot stall.
//   Pattern registers are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while idle, as the block does not enforce it.
//   Reset: all LEDs read as off/black (per-entry valid bits cleared at once),
//   blink phase lit, patterns 0xF8 and 0xC0; no clearing pass is needed.
`default_nettype none

module rgb_led_table_ws2812_encoder_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ledenc_pkg::in_item_t  in_item,
  output logic                       out_valid,
  output ledenc_pkg::out_item_t      out_item,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [7:0]            cfg_wdata
);

  localparam int AW = ledenc_pkg::LED_IDX_W;

  ledenc_pkg::state_t    state_r, state_nxt;
  ledenc_pkg::byte_sel_t sel_r, sel_nxt;
  logic [AW-1:0]         led_r, led_nxt;
  logic                  phase_r, phase_nxt;
  logic [7:0]            one_pat_r, zero_pat_r;
  logic [ledenc_pkg::LED_COUNT-1:0] valid_r;
  logic                  rd_valid_r;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [AW-1:0]         ram_waddr;
  ledenc_pkg::led_entry_t wr_entry;
  logic [ledenc_pkg::ENTRY_W-1:0] rd_raw;
  ledenc_pkg::led_entry_t rd_entry;
  logic                  lit;
  logic [23:0]           shown;
  logic [7:0]            sel_byte;
  ledenc_pkg::enc_req_t  req;
  logic                  wr_ok;

  assign busy = (state_r != ledenc_pkg::ST_IDLE);

  // Write qualifier: skip the empty write, drop out-of-range indexes
  assign wr_ok = !((in_item.led_num == '0) && (in_item.power_mode == ledenc_pkg::MODE_OFF))
               && (in_item.led_num < ledenc_pkg::LED_COUNT_IX);
  assign ram_waddr = in_item.led_num[AW-1:0];
  assign wr_entry  = '{mode: in_item.power_mode,
                       color: {in_item.red, in_item.green, in_item.blue}};

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ledenc_pkg::ST_IDLE;
      sel_r   <= ledenc_pkg::BYTE_GREEN;
      led_r   <= '0;
      phase_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      led_r   <= led_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Next state, RAM access and emit control
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    led_nxt   = led_r;
    phase_nxt = phase_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = led_r;
    req.emit  = 1'b0;
    req.data  = sel_byte;
    req.last  = 1'b0;
    unique case (state_r)
      ledenc_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_item.command)
            ledenc_pkg::CMD_WRITE: begin
              ram_we = wr_ok;
            end
            ledenc_pkg::CMD_BLINK: begin
              phase_nxt = ~phase_r;
              led_nxt   = '0;
              state_nxt = ledenc_pkg::ST_READ;
            end
            ledenc_pkg::CMD_REFRESH: begin
              led_nxt   = '0;
              state_nxt = ledenc_pkg::ST_READ;
            end
            default: begin
              state_nxt = ledenc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ledenc_pkg::ST_READ: begin
        ram_re    = 1'b1;
        sel_nxt   = ledenc_pkg::BYTE_GREEN;
        state_nxt = ledenc_pkg::ST_EMIT;
      end
      ledenc_pkg::ST_EMIT: begin
        req.emit = 1'b1;
        case (sel_r)
          ledenc_pkg::BYTE_GREEN: sel_nxt = ledenc_pkg::BYTE_RED;
          ledenc_pkg::BYTE_RED:   sel_nxt = ledenc_pkg::BYTE_BLUE;
          ledenc_pkg::BYTE_BLUE: begin
            if (led_r == ledenc_pkg::LED_LAST) begin
              req.last  = 1'b1;
              state_nxt = ledenc_pkg::ST_IDLE;
            end else begin
              // Prefetch the next LED while its bytes are still to come
              led_nxt   = led_r + 1'b1;
              ram_re    = 1'b1;
              ram_raddr = led_r + 1'b1;
              sel_nxt   = ledenc_pkg::BYTE_GREEN;
            end
          end
          default: begin
            state_nxt = ledenc_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ledenc_pkg::ST_IDLE;
      end
    endcase
  end

  // Entry valid bits: unwritten entries read as off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  // Track validity alongside the RAM read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
    end
  end

  // Pattern registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_pat_r  <= ledenc_pkg::ONE_PATTERN_RST;
      zero_pat_r <= ledenc_pkg::ZERO_PATTERN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ledenc_pkg::CFG_ONE_PATTERN:  one_pat_r  <= cfg_wdata;
        ledenc_pkg::CFG_ZERO_PATTERN: zero_pat_r <= cfg_wdata;
        default: begin
          one_pat_r <= one_pat_r;
        end
      endcase
    end
  end

  ledenc_ram #(
    .WIDTH(ledenc_pkg::ENTRY_W),
    .DEPTH(ledenc_pkg::LED_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_raw)
  );

  // Shown color: lit when on, or blinking in the lit phase
  always_comb begin
    rd_entry = rd_valid_r ? ledenc_pkg::led_entry_t'(rd_raw) : '0;
    lit      = (rd_entry.mode == ledenc_pkg::MODE_ON)
            || ((rd_entry.mode == ledenc_pkg::MODE_BLINK) && phase_r);
    shown    = lit ? rd_entry.color : 24'd0;
  end

  // Pick the byte for this step: green, red, blue
  always_comb begin
    case (sel_r)
      ledenc_pkg::BYTE_GREEN: sel_byte = shown[15:8];
      ledenc_pkg::BYTE_RED:   sel_byte = shown[23:16];
      ledenc_pkg::BYTE_BLUE:  sel_byte = shown[7:0];
      default:                sel_byte = 8'd0;
    endcase
  end

  ledenc_enc u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .one_pattern (one_pat_r),
    .zero_pattern(zero_pat_r),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

`ifndef SYNTH
  // Every item comes from an emit step of the sequencer
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ledenc_pkg::ST_EMIT))
    else $error("item emitted outside the emit state");

  // A frame end is followed by a gap before any new item
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("item directly after the last item of a frame");

  // An item that is not the last leaves the sequencer still busy
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("sequencer went idle in the middle of a frame");

  // The table is only written while no refresh reads it
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ledenc_pkg::ST_IDLE) && !ram_re)
    else $error("table write overlaps a refresh");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for the LED table encoder: a queued command driver, a word monitor
// and a table predictor. Depends on ledenc_pkg and rgb_led_table_ws2812_encoder_unit.
`timescale 1ns / 1ps

module testbench;
  import ledenc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_ONE_PATTERN;
  logic [7:0]  cfg_wdata = '0;

  // Predicted table, blink phase and pattern bytes
  logic [23:0] exp_color [LED_COUNT];
  logic [1:0]  led_mode [LED_COUNT];
  logic        blink_lit;
  logic [7:0]  pat_one;
  logic [7:0]  pat_zero;

  in_item_t    pending_cmds[$];
  out_item_t   frame_words[$];

  int gap_left = 0;
  int burst_left = 0;
  int errors = 0;
  int words_checked = 0;
  int cmds_taken = 0;
  int table_writes = 0;
  int frames = 0;
  int blink_ticks = 0;
  int cycle_count = 0;

  rgb_led_table_ws2812_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Spread one color byte into eight pattern bytes, MSB first in the top byte
  function automatic logic [63:0] spread_byte(input logic [7:0] data);
    logic [63:0] word;
    word = '0;
    for (int i = 7; i >= 0; i--) begin
      word = {word[55:0], data[i] ? pat_one : pat_zero};
    end
    return word;
  endfunction

  // Queue the whole frame: green, red, blue of every LED in index order
  task automatic queue_frame();
    logic [23:0] shown;
    logic [7:0]  bytes [3];
    out_item_t   word;
    for (int n = 0; n < LED_COUNT; n++) begin
      if (led_mode[n] == MODE_ON || (led_mode[n] == MODE_BLINK && blink_lit)) begin
        shown = exp_color[n];
      end else begin
        shown = '0;
      end
      bytes[0] = shown[15:8];
      bytes[1] = shown[23:16];
      bytes[2] = shown[7:0];
      for (int k = 0; k < 3; k++) begin
        word.spi_word = spread_byte(bytes[k]);
        word.last     = (n == LED_COUNT - 1) && (k == 2);
        frame_words.push_back(word);
      end
    end
    frames++;
  endtask

  // Update the predicted table for one accepted command
  task automatic apply_command(input in_item_t cmd);
    logic [LED_IDX_W-1:0] slot;
    slot = cmd.led_num[LED_IDX_W-1:0];
    cmds_taken++;
    case (cmd.command)
      CMD_WRITE: begin
        // drop empty writes and writes past the end of the table
        if (!(cmd.led_num == '0 && cmd.power_mode == MODE_OFF) &&
            cmd.led_num < LED_COUNT_IX) begin
          exp_color[slot] = {cmd.red, cmd.green, cmd.blue};
          led_mode[slot]  = cmd.power_mode;
          table_writes++;
        end
      end
      CMD_BLINK: begin
        blink_lit = ~blink_lit;
        blink_ticks++;
        queue_frame();
      end
      CMD_REFRESH: begin
        queue_frame();
      end
      default: ;
    endcase
  endtask

  // Cycles to wait before the next item; some stretches run back to back
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Drive the next pending item; hold it while busy
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(in_item);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_item <= pending_cmds.pop_front();
          start <= 1'b1;
          gap_left = draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare every strobed word with the oldest predicted one
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (frame_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b",
                 $time, out_item.spi_word, out_item.last);
        errors++;
      end else begin
        want = frame_words.pop_front();
        words_checked++;
        if (out_item.spi_word !== want.spi_word) begin
          $display("%0t: spi_word mismatch, expected %h, actual %h",
                   $time, want.spi_word, out_item.spi_word);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Some tests failed");
    $finish;
  end

  task automatic push_cmd(input logic [1:0] cmd, input int idx, input logic [1:0] mode,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_item_t it;
    it.command    = cmd;
    it.led_num    = IN_IDX_W'(idx);
    it.power_mode = mode;
    it.red        = r;
    it.green      = g;
    it.blue       = b;
    pending_cmds.push_back(it);
  endtask

  // Wait until every item is taken, every word has come and the block is quiet
  task automatic drain();
    while (pending_cmds.size() != 0 || start || frame_words.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pattern(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ONE_PATTERN) pat_one = val;
    else pat_zero = val;
  endtask

  function automatic logic [7:0] color_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly writes into the table with random refreshes and blink ticks between;
  // a few empty, out-of-range and unused commands are mixed in
  task automatic run_random_phase(input int count);
    int done;
    int pick;
    int idx;
    logic [1:0] cmd;
    logic [1:0] mode;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 7) == 0) ? $urandom_range(LED_COUNT, 31)
                                          : $urandom_range(0, LED_COUNT - 1);
      mode = 2'($urandom_range(0, 3));
      if (pick < 62) cmd = CMD_WRITE;
      else if (pick < 76) cmd = CMD_BLINK;
      else if (pick < 94) cmd = CMD_REFRESH;
      else cmd = CMD_NOP;
      if (cmd == CMD_WRITE && $urandom_range(0, 15) == 0) begin
        idx  = 0;
        mode = MODE_OFF;
      end
      push_cmd(cmd, idx, mode, color_byte(), color_byte(), color_byte());
      if (cmd == CMD_BLINK || cmd == CMD_REFRESH ||
          (cmd == CMD_WRITE && idx < LED_COUNT && !(idx == 0 && mode == MODE_OFF))) begin
        done++;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] ones [6];
    logic [7:0] zeros [6];
    for (int n = 0; n < LED_COUNT; n++) begin
      exp_color[n] = '0;
      led_mode[n]  = MODE_OFF;
    end
    blink_lit = 1'b1;
    pat_one   = ONE_PATTERN_RST;
    pat_zero  = ZERO_PATTERN_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset patterns
    push_cmd(CMD_REFRESH, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_WRITE, 0, MODE_ON, 8'h12, 8'h34, 8'h56);
    push_cmd(CMD_WRITE, 0, MODE_OFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_REFRESH, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_WRITE, 15, MODE_ON, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_WRITE, 1, MODE_BLINK, 8'hA5, 8'h5A, 8'hC3);
    push_cmd(CMD_WRITE, 2, MODE_BLACK, 8'hFF, 8'h80, 8'h01);
    push_cmd(CMD_WRITE, 3, MODE_OFF, 8'h7F, 8'hFE, 8'h10);
    push_cmd(CMD_WRITE, 16, MODE_ON, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_WRITE, 31, MODE_BLINK, 8'hAA, 8'hBB, 8'hCC);
    push_cmd(CMD_WRITE, 14, MODE_ON, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_WRITE, 7, MODE_BLINK, 8'h80, 8'h01, 8'hFF);
    push_cmd(CMD_NOP, 31, MODE_BLACK, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_REFRESH, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_BLINK, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_REFRESH, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_BLINK, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_WRITE, 0, MODE_BLACK, 8'h11, 8'h22, 8'h33);
    push_cmd(CMD_NOP, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_REFRESH, 0, MODE_OFF, 8'h00, 8'h00, 8'h00);
    drain();

    // Random phases, each under its own pair of patterns
    ones[0] = 8'hFF;  zeros[0] = 8'h00;
    ones[1] = 8'h00;  zeros[1] = 8'hFF;
    ones[2] = 8'($urandom_range(0, 255));  zeros[2] = 8'($urandom_range(0, 255));
    ones[3] = 8'hAA;  zeros[3] = 8'h55;
    ones[4] = 8'h0F;  zeros[4] = 8'hF0;
    ones[5] = ONE_PATTERN_RST;  zeros[5] = ZERO_PATTERN_RST;
    for (int p = 0; p < 6; p++) begin
      write_pattern(CFG_ONE_PATTERN, ones[p]);
      write_pattern(CFG_ZERO_PATTERN, zeros[p]);
      run_random_phase(PHASE_ITEMS);
      drain();
    end

    $display("Ran %0d commands over 7 pattern settings: %0d table writes, %0d frames",
             cmds_taken, table_writes, frames);
    $display("including %0d blink ticks; %0d encoded words compared", blink_ticks,
             words_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== rgb_led_table_ws2812_encoder_unit.f =====
src/ledenc_pkg.sv
src/ledenc_ram.sv
src/ledenc_enc.sv
src/rgb_led_table_ws2812_encoder_unit.sv
test/testbench.sv
